@@ hw/rtl/afit_pkg.sv @@
package afit_pkg;

  localparam int SYS_N          = 6;
  localparam int ROW_LEN        = SYS_N + 1;          // matrix row plus right-hand side
  localparam int MEM_DEPTH      = SYS_N * ROW_LEN;
  localparam int ADDR_W         = $clog2(MEM_DEPTH);
  localparam int IDX_W          = 3;                  // holds 0..SYS_N
  localparam int QW             = 48;
  localparam int PAIR_N         = 3;
  localparam int FIELD_W        = 16;
  localparam int MAX_COORD_W    = 24;
  localparam int OUT_W          = 32;
  localparam int OUT_FRAC       = 16;
  localparam int THR_W          = 16;
  localparam int INV_N          = 4;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 24;

  localparam logic [1:0] PAIR_START = 2'd2;
  localparam logic [1:0] PAIR_NONE  = 2'd3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_NOINV    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic {OP_MUL, OP_DIV} op_t;

  typedef struct packed {
    logic start;
    op_t  op;
    q_t   a;
    q_t   b;
  } arith_req_t;

  typedef struct packed {
    logic done;
    q_t   res;
  } arith_rsp_t;

  typedef struct packed {
    logic [SYS_N-1:0][QW-1:0] x;
    logic [INV_N-1:0][QW-1:0] inv;
    status_t                  status;
  } sol_res_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [QW:0] d;
    d = {a[QW-1], a} - {b[QW-1], b};
    if (d[QW] != d[QW-1]) return d[QW] ? Q_MIN : Q_MAX;
    return d[QW-1:0];
  endfunction

  function automatic q_t sat_neg(q_t a);
    if (a == Q_MIN) return Q_MAX;
    return -a;
  endfunction

  function automatic logic [QW-1:0] mag(q_t v);
    if (v[QW-1]) return QW'(-v);
    return QW'(v);
  endfunction

  function automatic addr_t ent_addr(idx_t r, idx_t c);
    return ADDR_W'(int'(r) * ROW_LEN + int'(c));
  endfunction

endpackage

@@ hw/rtl/afit_in_if.sv @@
interface afit_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          pair_index;
  logic signed [afit_pkg::FIELD_W-1:0] src_x;
  logic signed [afit_pkg::FIELD_W-1:0] src_y;
  logic signed [afit_pkg::FIELD_W-1:0] dst_x;
  logic signed [afit_pkg::FIELD_W-1:0] dst_y;

  modport source (output valid, pair_index, src_x, src_y, dst_x, dst_y, input ready);
  modport sink   (input valid, pair_index, src_x, src_y, dst_x, dst_y, output ready);
endinterface

@@ hw/rtl/afit_out_if.sv @@
interface afit_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [afit_pkg::OUT_W-1:0] mat_00;
  logic signed [afit_pkg::OUT_W-1:0] mat_01;
  logic signed [afit_pkg::OUT_W-1:0] mat_10;
  logic signed [afit_pkg::OUT_W-1:0] mat_11;
  logic signed [afit_pkg::OUT_W-1:0] shift_x;
  logic signed [afit_pkg::OUT_W-1:0] shift_y;
  logic signed [afit_pkg::OUT_W-1:0] inv_00;
  logic signed [afit_pkg::OUT_W-1:0] inv_01;
  logic signed [afit_pkg::OUT_W-1:0] inv_10;
  logic signed [afit_pkg::OUT_W-1:0] inv_11;
  logic [1:0]                        status;

  modport source (output valid, mat_00, mat_01, mat_10, mat_11, shift_x, shift_y,
                  inv_00, inv_01, inv_10, inv_11, status, input ready);
  modport sink   (input valid, mat_00, mat_01, mat_10, mat_11, shift_x, shift_y,
                  inv_00, inv_01, inv_10, inv_11, status, output ready);
endinterface

@@ hw/rtl/affine_fit_three_points_with_inverse.sv @@
// Channel | Direction | Payload                                          | Transfer
// in_if   | sink      | pair_index, src_x, src_y, dst_x, dst_y           | valid & ready
// out_if  | source    | mat_00..mat_11, shift_x/y, inv_00..inv_11, status| valid & ready
// cfg     | write     | cfg_wr_data (singular_threshold)                 | cfg_wr_en
//
// Pairs 0 and 1 are only stored. Pair 2 runs the solve; its length is set by the
// bit-serial divider (48+FRAC_BITS quotient bits each, up to 31 quotients), plus the
// chunked multiplies and the read/write walk of the working memory. If pair 0 or 1 is
// missing at pair 2, the solver goes to done with status MISSING, then out_if registers it.
// Reset is synchronous, active low; it clears the loaded pairs and sets the threshold to 1.
// A result waiting on out_if holds the solver; pairs are taken only while it is idle.
module affine_fit_three_points_with_inverse #(
  parameter int COORD_BITS = afit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = afit_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [afit_pkg::THR_W-1:0] cfg_wr_data,
  afit_in_if.sink                    in_if,
  afit_out_if.source                 out_if
);
  import afit_pkg::*;

  localparam int SH = FRAC_BITS - OUT_FRAC;
  localparam logic signed [OUT_W-1:0] O_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] O_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [THR_W-1:0]  thr_r;
  logic [PAIR_N-1:0] mask_r;
  logic              in_fire, sol_idle, sol_valid, sol_take, start, missing, cw_en;
  logic [4*COORD_BITS-1:0] cw_data;
  sol_res_t          sol_res;
  logic              out_valid_r;
  logic signed [OUT_W-1:0] mat_r [SYS_N];
  logic signed [OUT_W-1:0] inv_r [INV_N];
  status_t           status_r;
  logic              zero_all, zero_inv;

  function automatic logic [COORD_BITS-1:0] coord_cut(logic signed [FIELD_W-1:0] f);
    logic signed [MAX_COORD_W-1:0] e;
    e = MAX_COORD_W'(f);
    return e[COORD_BITS-1:0];
  endfunction

  // floor shift to Q16.16, then clamp
  function automatic logic signed [OUT_W-1:0] to_q16(q_t v);
    q_t s;
    s = v >>> SH;
    if (s > QW'(O_MAX)) return O_MAX;
    if (s < QW'(O_MIN)) return O_MIN;
    return s[OUT_W-1:0];
  endfunction

  assign in_fire  = in_if.valid & in_if.ready;
  assign in_if.ready = sol_idle;
  assign cw_en    = in_fire && (in_if.pair_index != PAIR_NONE);
  assign start    = in_fire && (in_if.pair_index == PAIR_START);
  assign missing  = ~&mask_r[PAIR_N-2:0];
  assign cw_data  = {coord_cut(in_if.src_x), coord_cut(in_if.src_y),
                     coord_cut(in_if.dst_x), coord_cut(in_if.dst_y)};
  assign sol_take = sol_valid && (!out_valid_r || out_if.ready);

  afit_solver #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_solver (
    .clk(clk), .rst_n(rst_n), .start(start), .missing(missing), .thr(thr_r),
    .cw_en(cw_en), .cw_pair(in_if.pair_index), .cw_data(cw_data),
    .idle(sol_idle), .res_valid(sol_valid), .res_take(sol_take), .res(sol_res)
  );

  assign zero_all = (sol_res.status == ST_SINGULAR) || (sol_res.status == ST_MISSING);
  assign zero_inv = zero_all || (sol_res.status == ST_NOINV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_W'(1);
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (cw_en) mask_r <= mask_r | (PAIR_N'(1) << in_if.pair_index);
      if (sol_take)           out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sol_take) begin
      for (int n = 0; n < SYS_N; n++)
        mat_r[n] <= zero_all ? '0 : to_q16(q_t'(sol_res.x[n]));
      for (int n = 0; n < INV_N; n++)
        inv_r[n] <= zero_inv ? '0 : to_q16(q_t'(sol_res.inv[n]));
      status_r <= sol_res.status;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.mat_00  = mat_r[0];
  assign out_if.mat_01  = mat_r[1];
  assign out_if.mat_10  = mat_r[2];
  assign out_if.mat_11  = mat_r[3];
  assign out_if.shift_x = mat_r[4];
  assign out_if.shift_y = mat_r[5];
  assign out_if.inv_00  = inv_r[0];
  assign out_if.inv_01  = inv_r[1];
  assign out_if.inv_10  = inv_r[2];
  assign out_if.inv_11  = inv_r[3];
  assign out_if.status  = status_r;

endmodule

@@ hw/rtl/afit_arith.sv @@
module afit_arith #(
  parameter int FRAC_BITS = afit_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  afit_pkg::arith_req_t req,
  output afit_pkg::arith_rsp_t rsp
);
  import afit_pkg::*;

  localparam int NUM_W  = QW + FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int CHUNK  = 16;
  localparam int NCHUNK = QW / CHUNK;
  localparam int PROD_W = 2 * QW;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_t;

  astate_t           state_r;
  op_t               op_r;
  logic              neg_r;
  logic [QW-1:0]     ma_r;
  logic [QW-1:0]     mb_r;
  logic [PROD_W-1:0] acc_r;
  logic [NUM_W-1:0]  num_r;
  logic [QW-1:0]     rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  q_t                res_r;
  logic              done_r;

  logic [QW+CHUNK-1:0] pp;
  logic [PROD_W-1:0]   acc_nxt;
  logic [QW:0]         rem_sh;
  logic                ge;
  logic [QW-1:0]       rem_nxt;
  logic                ovf;
  logic [QW-2:0]       m;
  q_t                  fin;

  always_comb begin
    pp      = ma_r * mb_r[QW-1 -: CHUNK];
    acc_nxt = (acc_r << CHUNK) + PROD_W'(pp);
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, mb_r};
    rem_nxt = ge ? QW'(rem_sh - {1'b0, mb_r}) : rem_sh[QW-1:0];
    if (op_r == OP_MUL) begin
      ovf = |acc_r[PROD_W-1:FRAC_BITS+QW-1];
      m   = acc_r[FRAC_BITS+QW-2:FRAC_BITS];
    end else begin
      ovf = |quo_r[NUM_W-1:QW-1];
      m   = quo_r[QW-2:0];
    end
    if (ovf) fin = neg_r ? Q_MIN : Q_MAX;
    else     fin = neg_r ? -q_t'({1'b0, m}) : q_t'({1'b0, m});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            op_r    <= req.op;
            neg_r   <= req.a[QW-1] ^ req.b[QW-1];
            ma_r    <= mag(req.a);
            mb_r    <= mag(req.b);
            acc_r   <= '0;
            num_r   <= {mag(req.a), {FRAC_BITS{1'b0}}};
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= (req.op == OP_MUL) ? A_MUL : A_DIV;
          end
        end
        A_MUL: begin
          // high chunk of the multiplier first, accumulator shifts left
          acc_r <= acc_nxt;
          mb_r  <= mb_r << CHUNK;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NCHUNK - 1)) state_r <= A_FIN;
        end
        A_DIV: begin
          rem_r <= rem_nxt;
          num_r <= num_r << 1;
          quo_r <= {quo_r[NUM_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) state_r <= A_FIN;
        end
        A_FIN: begin
          res_r   <= fin;
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

@@ hw/rtl/afit_solver.sv @@
module afit_solver #(
  parameter int COORD_BITS = afit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = afit_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        missing,
  input  logic [afit_pkg::THR_W-1:0]  thr,
  input  logic                        cw_en,
  input  logic [1:0]                  cw_pair,
  input  logic [4*COORD_BITS-1:0]     cw_data,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_take,
  output afit_pkg::sol_res_t          res
);
  import afit_pkg::*;

  localparam int CW = COORD_BITS;
  localparam q_t Q_ONE = q_t'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL_RD, S_FILL_WR, S_SRCH_INIT, S_SRCH_RD, S_SRCH_CMP, S_SRCH_CHK,
    S_PIV_RD, S_PIV_LD, S_NORM_RD, S_NORM_DIV, S_NORM_WAIT, S_F_RD, S_F_LD,
    S_EL_RDI, S_EL_MUL, S_EL_RDJ, S_EL_WAIT, S_BK_RD, S_BK_Y, S_BK_RDM, S_BK_RDY,
    S_BK_MUL, S_BK_WAIT, S_BK_WR, S_DET_A, S_DET_AW, S_DET_BW, S_DET_CHK,
    S_INV_DIV, S_INV_WAIT, S_DONE
  } sstate_t;

  // working copy of the augmented system, row-major, rhs in the last column
  q_t            work_mem [MEM_DEPTH];
  logic [4*CW-1:0] coord_mem [PAIR_N];

  sstate_t       state_r;
  status_t       status_r;
  idx_t          i_r, j_r, k_r, br_r, bc_r;
  idx_t          rowmap_r [SYS_N];
  idx_t          colmap_r [SYS_N];
  logic [QW-1:0] best_r;
  q_t            piv_r, f_r, y_r, tmp_r, det_r;
  q_t            x_r [SYS_N];
  q_t            inv_r [INV_N];
  q_t            rd_data_r;
  logic [4*CW-1:0] coord_rd_r;

  logic          rd_en, wr_en, coord_rd_en;
  addr_t         rd_addr, wr_addr;
  q_t            wr_data;
  idx_t          pcol;
  q_t            fill_val, inv_num;
  q_t            qsx, qsy, qdx, qdy;
  arith_req_t    areq;
  arith_rsp_t    arsp;

  afit_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk(clk), .rst_n(rst_n), .req(areq), .rsp(arsp)
  );

  function automatic q_t coord_q(logic [CW-1:0] c);
    logic signed [63:0] w;
    w = {{(64-CW){c[CW-1]}}, c};
    w = w <<< FRAC_BITS;
    if (w > 64'(Q_MAX)) return Q_MAX;
    if (w < 64'(Q_MIN)) return Q_MIN;
    return QW'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (cw_en) coord_mem[cw_pair] <= cw_data;
    if (coord_rd_en) coord_rd_r <= coord_mem[j_r[2:1]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) work_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= work_mem[rd_addr];
  end

  always_comb begin
    qsx  = coord_q(coord_rd_r[4*CW-1 -: CW]);
    qsy  = coord_q(coord_rd_r[3*CW-1 -: CW]);
    qdx  = coord_q(coord_rd_r[2*CW-1 -: CW]);
    qdy  = coord_q(coord_rd_r[CW-1:0]);
    unique case (k_r)
      3'd0:    fill_val = j_r[0] ? '0 : qsx;
      3'd1:    fill_val = j_r[0] ? '0 : qsy;
      3'd2:    fill_val = j_r[0] ? qsx : '0;
      3'd3:    fill_val = j_r[0] ? qsy : '0;
      3'd4:    fill_val = j_r[0] ? '0 : Q_ONE;
      3'd5:    fill_val = j_r[0] ? Q_ONE : '0;
      3'd6:    fill_val = j_r[0] ? qdy : qdx;
      default: fill_val = '0;
    endcase
    pcol = (k_r == idx_t'(SYS_N)) ? k_r : colmap_r[k_r];
    unique case (k_r[1:0])
      2'd0:    inv_num = x_r[3];
      2'd1:    inv_num = sat_neg(x_r[1]);
      2'd2:    inv_num = sat_neg(x_r[2]);
      default: inv_num = x_r[0];
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    coord_rd_en = 1'b0;
    areq        = '0;
    unique case (state_r)
      S_FILL_RD: coord_rd_en = 1'b1;
      S_FILL_WR: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(j_r, k_r);
        wr_data = fill_val;
      end
      S_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[j_r], colmap_r[k_r]);
      end
      S_PIV_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[i_r], colmap_r[i_r]);
      end
      S_NORM_RD, S_EL_RDI: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[i_r], pcol);
      end
      S_NORM_DIV: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = rd_data_r;
        areq.b     = piv_r;
      end
      S_NORM_WAIT: begin
        wr_en   = arsp.done;
        wr_addr = ent_addr(rowmap_r[i_r], pcol);
        wr_data = arsp.res;
      end
      S_F_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[j_r], colmap_r[i_r]);
      end
      S_EL_MUL: begin
        areq.start = 1'b1;
        areq.op    = OP_MUL;
        areq.a     = f_r;
        areq.b     = rd_data_r;
      end
      S_EL_RDJ: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[j_r], pcol);
      end
      S_EL_WAIT: begin
        wr_en   = arsp.done;
        wr_addr = ent_addr(rowmap_r[j_r], pcol);
        wr_data = sat_sub(rd_data_r, arsp.res);
      end
      S_BK_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[i_r], idx_t'(SYS_N));
      end
      S_BK_RDM: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[i_r], colmap_r[k_r]);
      end
      S_BK_RDY: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(rowmap_r[k_r], idx_t'(SYS_N));
      end
      S_BK_MUL: begin
        areq.start = 1'b1;
        areq.op    = OP_MUL;
        areq.a     = tmp_r;
        areq.b     = rd_data_r;
      end
      S_BK_WR: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(rowmap_r[i_r], idx_t'(SYS_N));
        wr_data = y_r;
      end
      S_DET_A: begin
        areq.start = 1'b1;
        areq.op    = OP_MUL;
        areq.a     = x_r[0];
        areq.b     = x_r[3];
      end
      S_DET_AW: begin
        areq.start = arsp.done;
        areq.op    = OP_MUL;
        areq.a     = x_r[1];
        areq.b     = x_r[2];
      end
      S_INV_DIV: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = inv_num;
        areq.b     = det_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (missing) begin
              status_r <= ST_MISSING;
              state_r  <= S_DONE;
            end else begin
              status_r <= ST_OK;
              for (int n = 0; n < SYS_N; n++) begin
                rowmap_r[n] <= idx_t'(n);
                colmap_r[n] <= idx_t'(n);
              end
              j_r     <= '0;
              k_r     <= '0;
              state_r <= S_FILL_RD;
            end
          end
        end
        S_FILL_RD: state_r <= S_FILL_WR;
        S_FILL_WR: begin
          state_r <= S_FILL_RD;
          if (k_r == idx_t'(SYS_N)) begin
            k_r <= '0;
            if (j_r == idx_t'(SYS_N - 1)) begin
              i_r     <= '0;
              state_r <= S_SRCH_INIT;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_SRCH_INIT: begin
          best_r  <= '0;
          br_r    <= i_r;
          bc_r    <= i_r;
          j_r     <= i_r;
          k_r     <= i_r;
          state_r <= S_SRCH_RD;
        end
        S_SRCH_RD: state_r <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          // strict compare keeps the first maximum in row-major order
          if (mag(rd_data_r) > best_r) begin
            best_r <= mag(rd_data_r);
            br_r   <= j_r;
            bc_r   <= k_r;
          end
          state_r <= S_SRCH_RD;
          if (k_r == idx_t'(SYS_N - 1)) begin
            k_r <= i_r;
            if (j_r == idx_t'(SYS_N - 1)) state_r <= S_SRCH_CHK;
            else                          j_r     <= j_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_SRCH_CHK: begin
          if (best_r <= QW'(thr)) begin
            status_r <= ST_SINGULAR;
            state_r  <= S_DONE;
          end else begin
            rowmap_r[i_r]  <= rowmap_r[br_r];
            rowmap_r[br_r] <= rowmap_r[i_r];
            colmap_r[i_r]  <= colmap_r[bc_r];
            colmap_r[bc_r] <= colmap_r[i_r];
            state_r        <= S_PIV_RD;
          end
        end
        S_PIV_RD: state_r <= S_PIV_LD;
        S_PIV_LD: begin
          piv_r   <= rd_data_r;
          k_r     <= i_r;
          state_r <= S_NORM_RD;
        end
        S_NORM_RD:  state_r <= S_NORM_DIV;
        S_NORM_DIV: state_r <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (arsp.done) begin
            if (k_r == idx_t'(SYS_N)) begin
              if (i_r == idx_t'(SYS_N - 1)) begin
                state_r <= S_BK_RD;
              end else begin
                j_r     <= i_r + 1'b1;
                state_r <= S_F_RD;
              end
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_NORM_RD;
            end
          end
        end
        S_F_RD: state_r <= S_F_LD;
        S_F_LD: begin
          f_r     <= rd_data_r;
          k_r     <= i_r;
          state_r <= S_EL_RDI;
        end
        S_EL_RDI: state_r <= S_EL_MUL;
        S_EL_MUL: state_r <= S_EL_RDJ;
        S_EL_RDJ: state_r <= S_EL_WAIT;
        S_EL_WAIT: begin
          if (arsp.done) begin
            if (k_r == idx_t'(SYS_N)) begin
              if (j_r == idx_t'(SYS_N - 1)) begin
                i_r     <= i_r + 1'b1;
                state_r <= S_SRCH_INIT;
              end else begin
                j_r     <= j_r + 1'b1;
                state_r <= S_F_RD;
              end
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_EL_RDI;
            end
          end
        end
        S_BK_RD: state_r <= S_BK_Y;
        S_BK_Y: begin
          y_r <= rd_data_r;
          if (i_r == idx_t'(SYS_N - 1)) begin
            state_r <= S_BK_WR;
          end else begin
            k_r     <= i_r + 1'b1;
            state_r <= S_BK_RDM;
          end
        end
        S_BK_RDM: state_r <= S_BK_RDY;
        S_BK_RDY: begin
          tmp_r   <= rd_data_r;
          state_r <= S_BK_MUL;
        end
        S_BK_MUL: state_r <= S_BK_WAIT;
        S_BK_WAIT: begin
          if (arsp.done) begin
            y_r <= sat_sub(y_r, arsp.res);
            if (k_r == idx_t'(SYS_N - 1)) begin
              state_r <= S_BK_WR;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_BK_RDM;
            end
          end
        end
        S_BK_WR: begin
          // undo the column permutation on the way out
          x_r[colmap_r[i_r]] <= y_r;
          if (i_r == '0) begin
            state_r <= S_DET_A;
          end else begin
            i_r     <= i_r - 1'b1;
            state_r <= S_BK_RD;
          end
        end
        S_DET_A: state_r <= S_DET_AW;
        S_DET_AW: begin
          if (arsp.done) begin
            tmp_r   <= arsp.res;
            state_r <= S_DET_BW;
          end
        end
        S_DET_BW: begin
          if (arsp.done) begin
            det_r   <= sat_sub(tmp_r, arsp.res);
            state_r <= S_DET_CHK;
          end
        end
        S_DET_CHK: begin
          if (det_r == '0 || mag(det_r) < QW'(thr)) begin
            status_r <= ST_NOINV;
            state_r  <= S_DONE;
          end else begin
            k_r     <= '0;
            state_r <= S_INV_DIV;
          end
        end
        S_INV_DIV: state_r <= S_INV_WAIT;
        S_INV_WAIT: begin
          if (arsp.done) begin
            inv_r[k_r[1:0]] <= arsp.res;
            if (k_r == idx_t'(INV_N - 1)) begin
              state_r <= S_DONE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_INV_DIV;
            end
          end
        end
        S_DONE: begin
          if (res_take) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int n = 0; n < SYS_N; n++) res.x[n] = x_r[n];
    for (int n = 0; n < INV_N; n++) res.inv[n] = inv_r[n];
    res.status = status_r;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

endmodule

@@ hw/rtl/afit_checker.sv @@
module afit_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_pair_index,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [afit_pkg::OUT_W-1:0] mat_00, mat_01, mat_10, mat_11, shift_x, shift_y,
  input logic [afit_pkg::OUT_W-1:0] inv_00, inv_01, inv_10, inv_11,
  input logic [1:0]                 status
);
  import afit_pkg::*;

  logic inv_zero, all_zero;
  assign inv_zero = (inv_00 == '0) && (inv_01 == '0) && (inv_10 == '0) && (inv_11 == '0);
  assign all_zero = inv_zero && (mat_00 == '0) && (mat_01 == '0) && (mat_10 == '0)
                    && (mat_11 == '0) && (shift_x == '0) && (shift_y == '0);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(mat_00))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_SINGULAR || status == ST_MISSING) |-> all_zero)
    else $error("failed solve carries nonzero values");

  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_NOINV |-> inv_zero)
    else $error("non-invertible result carries an inverse");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_pair_index == PAIR_START |=> !in_ready)
    else $error("input still taken after a solve started");

endmodule

bind affine_fit_three_points_with_inverse afit_checker u_afit_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_pair_index(in_if.pair_index),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .mat_00(out_if.mat_00), .mat_01(out_if.mat_01), .mat_10(out_if.mat_10),
  .mat_11(out_if.mat_11), .shift_x(out_if.shift_x), .shift_y(out_if.shift_y),
  .inv_00(out_if.inv_00), .inv_01(out_if.inv_01), .inv_10(out_if.inv_10),
  .inv_11(out_if.inv_11), .status(out_if.status)
);
